// ----- hdl/scfb_pkg.sv -----
// Shared types, constants and CRC helper for the speed command frame builder.
`timescale 1ns / 1ps

package scfb_pkg;

  // Field widths
  localparam int unsigned THROTTLE_W = 11;
  localparam int unsigned THR_MAG_W  = THROTTLE_W - 1;
  localparam int unsigned GEAR_W     = 2;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CTRL_W     = 3;
  localparam int unsigned ALIVE_W    = 8;
  localparam int unsigned CRC_W      = 8;

  // throttle magnitude times max speed always fits in 26 bits
  localparam int unsigned PROD_W       = THR_MAG_W + SPEED_W;
  // floor(p / 1000) == (p * ceil(2^36 / 1000)) >> 36 for every p below 2^26
  localparam int unsigned RECIP_W      = 27;
  localparam int unsigned RECIP_SHIFT  = 36;
  localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
  localparam int unsigned RECIP_PROD_W = PROD_W + RECIP_W;
  localparam int unsigned QUOT_W       = RECIP_PROD_W - RECIP_SHIFT;

  // Gear codes
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 2'd0;
  localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_REVERSE = 2'd2;

  // Control byte bits
  localparam logic [CTRL_W-1:0] CTRL_ENABLED = 3'b001;
  localparam logic [CTRL_W-1:0] CTRL_DRIVE   = 3'b010;
  localparam logic [CTRL_W-1:0] CTRL_REVERSE = 3'b100;

  // CRC8, MSB first, init zero
  localparam logic [CRC_W-1:0] CRC_POLY = 8'hAD;
  localparam logic [CRC_W-1:0] CRC_INIT = 8'h00;

  // Payload byte order on the wire, one CRC stage per byte
  localparam int unsigned CRC_STAGES = 6;
  localparam logic [2:0] BYTE_SPEED_LO  = 3'd0;
  localparam logic [2:0] BYTE_SPEED_HI  = 3'd1;
  localparam logic [2:0] BYTE_TORQUE_LO = 3'd2;
  localparam logic [2:0] BYTE_TORQUE_HI = 3'd3;
  localparam logic [2:0] BYTE_CONTROL   = 3'd4;
  localparam logic [2:0] BYTE_ALIVE     = 3'd5;

  typedef struct packed {
    logic signed [THROTTLE_W-1:0] throttle;
    logic [GEAR_W-1:0]            gear;
    logic                         enable;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_command;
    logic [CTRL_W-1:0]  control_flags;
    logic [ALIVE_W-1:0] alive_count;
    logic [CRC_W-1:0]   checksum;
  } out_item_t;

  // One byte of CRC8 update
  function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/scfb_speed.sv -----
// Speed command datapath: gated multiply, divide by 1000 via reciprocal, saturate.
`timescale 1ns / 1ps

module scfb_speed (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  scfb_pkg::in_item_t           item_i,
  input  logic [scfb_pkg::ALIVE_W-1:0] alive_i,
  input  logic [scfb_pkg::SPEED_W-1:0] max_speed_i,
  output logic                         valid_o,
  output logic [scfb_pkg::SPEED_W-1:0] speed_o,
  output logic [scfb_pkg::CTRL_W-1:0]  ctrl_o,
  output logic [scfb_pkg::ALIVE_W-1:0] alive_o
);
  import scfb_pkg::*;

  logic                    active;
  logic [THR_MAG_W-1:0]    thr_mag;
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic [CTRL_W-1:0]       ctrl_d, ctrl2_q, ctrl3_q, ctrl4_q;
  logic [ALIVE_W-1:0]      alive2_q, alive3_q, alive4_q;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [QUOT_W-1:0]       quot_d, quot_q;
  logic [SPEED_W-1:0]      speed_d, speed_q;
  logic [2:0]              valid_q;

  // Stage 1: speed only when enabled, in gear and throttle strictly positive
  assign thr_mag = item_i.throttle[THR_MAG_W-1:0];
  assign active  = item_i.enable && (item_i.gear != GEAR_NEUTRAL) &&
                   !item_i.throttle[THROTTLE_W-1] && (item_i.throttle != '0);

  always_comb begin
    prod_d = '0;
    if (active) begin
      prod_d = {{(PROD_W-THR_MAG_W){1'b0}}, thr_mag} *
               {{(PROD_W-SPEED_W){1'b0}}, max_speed_i};
    end
  end

  // Control byte: gear code 3 reports neither drive nor reverse
  always_comb begin
    unique case (item_i.gear)
      GEAR_DRIVE:   ctrl_d = CTRL_ENABLED | CTRL_DRIVE;
      GEAR_REVERSE: ctrl_d = CTRL_ENABLED | CTRL_REVERSE;
      default:      ctrl_d = CTRL_ENABLED;
    endcase
  end

  // Stage 2: quotient by reciprocal multiply, exact for the product range
  assign recip_prod = {{RECIP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, RECIP};
  assign quot_d     = recip_prod[RECIP_PROD_W-1 -: QUOT_W];

  // Stage 3: clamp to 16 bits
  assign speed_d = quot_q[QUOT_W-1] ? '1 : quot_q[SPEED_W-1:0];

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q   <= prod_d;
      ctrl2_q  <= ctrl_d;
      alive2_q <= alive_i;
      quot_q   <= quot_d;
      ctrl3_q  <= ctrl2_q;
      alive3_q <= alive2_q;
      speed_q  <= speed_d;
      ctrl4_q  <= ctrl3_q;
      alive4_q <= alive3_q;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o = valid_q[2];
  assign speed_o = speed_q;
  assign ctrl_o  = ctrl4_q;
  assign alive_o = alive4_q;

endmodule

// ----- hdl/scfb_crc_pipe.sv -----
// CRC8 over the six payload bytes, one byte per pipeline stage.
`timescale 1ns / 1ps

module scfb_crc_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [scfb_pkg::SPEED_W-1:0] speed_i,
  input  logic [scfb_pkg::CTRL_W-1:0]  ctrl_i,
  input  logic [scfb_pkg::ALIVE_W-1:0] alive_i,
  output logic                         valid_o,
  output scfb_pkg::out_item_t          frame_o
);
  import scfb_pkg::*;

  out_item_t             stage_in [CRC_STAGES];
  out_item_t             stage_d  [CRC_STAGES];
  out_item_t             stage_q  [CRC_STAGES];
  logic [CRC_STAGES-1:0] valid_q;

  // Payload byte seen by a given stage; torque bytes are always zero
  function automatic logic [7:0] frame_byte(input out_item_t f, input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      BYTE_SPEED_LO:  b = f.speed_command[7:0];
      BYTE_SPEED_HI:  b = f.speed_command[15:8];
      BYTE_TORQUE_LO: b = 8'h00;
      BYTE_TORQUE_HI: b = 8'h00;
      BYTE_CONTROL:   b = {{(8-CTRL_W){1'b0}}, f.control_flags};
      BYTE_ALIVE:     b = f.alive_count;
      default:        b = 8'h00;
    endcase
    return b;
  endfunction

  // Chain the stages; first stage starts from the init value
  always_comb begin
    stage_in[0] = '{speed_command: speed_i, control_flags: ctrl_i,
                    alive_count: alive_i, checksum: CRC_INIT};
    for (int k = 1; k < CRC_STAGES; k++) begin
      stage_in[k] = stage_q[k-1];
    end
  end

  for (genvar g = 0; g < CRC_STAGES; g++) begin : g_stage
    always_comb begin
      stage_d[g]          = stage_in[g];
      stage_d[g].checksum = crc8_byte(stage_in[g].checksum,
                                      frame_byte(stage_in[g], 3'(g)));
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stage_q[g] <= stage_d[g];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[CRC_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[CRC_STAGES-1];
  assign frame_o = stage_q[CRC_STAGES-1];

endmodule

// ----- hdl/speed_command_frame_builder_core.sv -----
// Top level: inverter speed command frame builder with alive counter and CRC8.
// Throughput: one frame per cycle, except while the output is stalled;
// a 10-register pipeline (input register, multiply, reciprocal multiply, clamp,
// then one CRC byte per stage, the last being the output).
// The whole pipeline holds while a result waits under stall.
// Reset clears all stage valids, the alive counter and max_speed (to 0).
`timescale 1ns / 1ps

module speed_command_frame_builder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [scfb_pkg::SPEED_W-1:0] cfg_data_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  scfb_pkg::in_item_t           in_item_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output scfb_pkg::out_item_t          out_item_o
);
  import scfb_pkg::*;

  logic               adv;
  logic               in_xfer;
  logic [SPEED_W-1:0] max_speed_q;
  logic [ALIVE_W-1:0] alive_d, alive_q;
  logic               s1_valid_q;
  in_item_t           s1_item_q;
  logic [ALIVE_W-1:0] s1_alive_q;
  logic               spd_valid;
  logic [SPEED_W-1:0] spd_speed;
  logic [CTRL_W-1:0]  spd_ctrl;
  logic [ALIVE_W-1:0] spd_alive;

  // Pipeline moves unless a finished result is held off
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign in_xfer    = in_valid_i && adv;

  // Config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_speed_q <= cfg_data_i;
    end
  end

  // Rolling alive counter, bumped on every input transfer
  assign alive_d = alive_q + ALIVE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        alive_q <= alive_d;
      end
      if (adv) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q  <= in_item_i;
      s1_alive_q <= alive_d;
    end
  end

  scfb_speed u_speed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (s1_valid_q),
    .item_i     (s1_item_q),
    .alive_i    (s1_alive_q),
    .max_speed_i(max_speed_q),
    .valid_o    (spd_valid),
    .speed_o    (spd_speed),
    .ctrl_o     (spd_ctrl),
    .alive_o    (spd_alive)
  );

  scfb_crc_pipe u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(spd_valid),
    .speed_i(spd_speed),
    .ctrl_i (spd_ctrl),
    .alive_i(spd_alive),
    .valid_o(out_valid_o),
    .frame_o(out_item_o)
  );

endmodule
